// ===== design/pip_pkg.sv =====
// shared constants, types and command structs for the point-in-polygon tester
package pip_pkg;

	// default sizes of the vertex store and the internal coordinate width
	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_BITS_DEF   = 16;

	// fixed field widths on the ports
	localparam int CFG_W   = 7;
	localparam int SLOT_W  = 6;
	localparam int IN_CW   = 16;

	// opcodes carried in tuser
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic start;    // latch query point, clear parity
		logic wr_en;    // write one vertex into the store
		logic rd_en;    // issue one store read
		logic first;    // this read is the wrap-around vertex
		logic out_load; // move parity into the output register
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic busy;     // edge pipeline still holds work
	} stat_t;

endpackage

// ===== design/point_in_polygon_test.sv =====
// top level of the crossing-number point-in-polygon tester
//
// Load transactions (tuser 0) write one vertex into the vertex store; loads to a
// slot at or above MAX_VERTICES are dropped. Test transactions (tuser 1) walk the
// polygon edges with one store read per cycle, so a test with n vertices in use
// (vertex_count, saturated to MAX_VERTICES) keeps the input side busy from
// acceptance until the next transaction can be taken; the busy time is set by the
// single read port of the vertex store, which delivers one vertex per cycle, plus
// the depth of the edge pipeline (store read, differences, cross products,
// parity). A test with zero vertices skips the store reads and returns outside.
// The result waits in an output register; loads are accepted while it waits.
// vertex_count must be written only while no test is in flight; the block itself
// does not enforce it. Vertices must be loaded before a test reads them; the
// store has no reset.
module point_in_polygon_test #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// vertex_index [5:0], coord_x [21:6], coord_y [37:22], zero [39:38]
	input  logic [39:0]               s_tdata,
	// opcode [0]
	input  logic                      s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// inside_res [0], zero [7:1]
	output logic [7:0]                m_tdata,
	input  logic                      cfg_we,
	input  logic [pip_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int IDX_W = $clog2(MAX_VERTICES);

	pip_pkg::cmd_t              cmd;
	pip_pkg::stat_t             status;
	logic [IDX_W-1:0]           rd_addr;
	logic [pip_pkg::SLOT_W-1:0] vertex_index;
	logic signed [pip_pkg::IN_CW-1:0] coord_x, coord_y;
	logic                       inside_res;

	// unpack the input transaction
	assign vertex_index = s_tdata[5:0];
	assign coord_x      = s_tdata[21:6];
	assign coord_y      = s_tdata[37:22];

	pip_ctrl #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tuser      (s_tuser),
		.vertex_index (vertex_index),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.status       (status),
		.cmd          (cmd),
		.rd_addr      (rd_addr)
	);

	pip_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.rd_addr      (rd_addr),
		.status       (status),
		.inside_res   (inside_res)
	);

	// pack the result transaction
	assign m_tdata = {7'b0, inside_res};

endmodule

// ===== design/pip_ram.sv =====
// generic simple dual-port ram with registered read
module pip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/pip_datapath.sv =====
// vertex store, edge crossing pipeline and parity register
module pip_datapath #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_VERTICES)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pip_pkg::cmd_t                     cmd,
	input  logic [pip_pkg::SLOT_W-1:0]        vertex_index,
	input  logic signed [pip_pkg::IN_CW-1:0]  coord_x,
	input  logic signed [pip_pkg::IN_CW-1:0]  coord_y,
	input  logic [IDX_W-1:0]                  rd_addr,
	output pip_pkg::stat_t                    status,
	output logic                              inside_res
);

	localparam int CB    = COORD_BITS;
	localparam int DW    = CB + 1;
	localparam int PW    = 2 * DW;
	localparam int SXW   = (pip_pkg::SLOT_W > IDX_W) ? pip_pkg::SLOT_W : IDX_W;

	logic signed [CB-1:0] cx, cy;
	logic [SXW-1:0]       slot_ext;
	logic [IDX_W-1:0]     wr_addr;
	logic [2*CB-1:0]      rdata;

	logic signed [CB-1:0] tx_q, ty_q;
	logic signed [CB-1:0] prev_x_q, prev_y_q;
	logic                 rdv_q, first_q;

	logic signed [CB-1:0] xi, yi;
	logic signed [DW-1:0] tx_e, ty_e, xi_e, yi_e, xj_e, yj_e;

	logic                 s1_v;
	logic signed [DW-1:0] dx_s1, ex_s1, dty_s1, dy_s1;
	logic                 cross_s1;

	logic signed [PW-1:0] lhs_c, rhs_c;
	logic                 s2_v;
	logic signed [PW-1:0] lhs_s2, rhs_s2;
	logic                 neg_s2, cross_s2;

	logic                 left;
	logic                 parity_q;
	logic                 inside_q;

	// input coordinates wrapped or sign-extended to the internal width
	assign cx = CB'(coord_x);
	assign cy = CB'(coord_y);

	// store slot from the input field
	assign slot_ext = SXW'(vertex_index);
	assign wr_addr  = slot_ext[IDX_W-1:0];

	// vertex store, y in the upper half
	pip_ram #(
		.WIDTH (2 * CB),
		.DEPTH (MAX_VERTICES)
	) u_store (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (wr_addr),
		.wdata ({cy, cx}),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// query point
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			tx_q <= cx;
			ty_q <= cy;
		end
	end

	// read data valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_q   <= 1'b0;
			first_q <= 1'b0;
		end else begin
			rdv_q   <= cmd.rd_en;
			first_q <= cmd.first;
		end
	end

	assign xi = rdata[CB-1:0];
	assign yi = rdata[2*CB-1:CB];

	// previous vertex closes the edge
	always_ff @(posedge clk) begin
		if (rdv_q) begin
			prev_x_q <= xi;
			prev_y_q <= yi;
		end
	end

	assign tx_e = {tx_q[CB-1], tx_q};
	assign ty_e = {ty_q[CB-1], ty_q};
	assign xi_e = {xi[CB-1], xi};
	assign yi_e = {yi[CB-1], yi};
	assign xj_e = {prev_x_q[CB-1], prev_x_q};
	assign yj_e = {prev_y_q[CB-1], prev_y_q};

	// stage 1: differences and straddle check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else begin
			s1_v <= rdv_q & ~first_q;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1    <= tx_e - xi_e;
		ex_s1    <= xj_e - xi_e;
		dty_s1   <= ty_e - yi_e;
		dy_s1    <= yj_e - yi_e;
		cross_s1 <= (yi > ty_q) != (prev_y_q > ty_q);
	end

	// stage 2: cross products
	assign lhs_c = dx_s1 * dy_s1;
	assign rhs_c = ex_s1 * dty_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else begin
			s2_v <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		lhs_s2   <= lhs_c;
		rhs_s2   <= rhs_c;
		neg_s2   <= dy_s1[DW-1];
		cross_s2 <= cross_s1;
	end

	// compare sense flips with the sign of dy
	assign left = neg_s2 ? (lhs_s2 > rhs_s2) : (lhs_s2 < rhs_s2);

	// crossing parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (cmd.start) begin
			parity_q <= 1'b0;
		end else if (s2_v && cross_s2 && left) begin
			parity_q <= ~parity_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			inside_q <= parity_q;
		end
	end

	assign inside_res  = inside_q;
	assign status.busy = rdv_q | s1_v | s2_v;

endmodule

// ===== design/pip_ctrl.sv =====
// controller: vertex count register, handshakes and test sequencing
module pip_ctrl #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	localparam int IDX_W = $clog2(MAX_VERTICES)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic                        s_tuser,
	input  logic [pip_pkg::SLOT_W-1:0]  vertex_index,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic                        cfg_we,
	input  logic [pip_pkg::CFG_W-1:0]   cfg_wdata,
	input  pip_pkg::stat_t              status,
	output pip_pkg::cmd_t               cmd,
	output logic [IDX_W-1:0]            rd_addr
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int CMP_W = (CNT_W > pip_pkg::CFG_W) ? CNT_W : pip_pkg::CFG_W;
	localparam int SXW   = (CMP_W > pip_pkg::SLOT_W) ? CMP_W : pip_pkg::SLOT_W;
	localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_VERTICES);
	localparam logic [SXW-1:0]   MAX_SX  = SXW'(MAX_VERTICES);

	pip_pkg::state_t          state_q, state_d;
	logic [pip_pkg::CFG_W-1:0] vcount_q;
	logic [CMP_W-1:0]         cnt_ext;
	logic [CNT_W-1:0]         n_eff;
	logic [CNT_W-1:0]         rd_cnt_q;
	logic [CNT_W-1:0]         addr_full;
	logic [SXW-1:0]           slot_ext;
	logic                     slot_ok;
	logic                     m_tvalid_q;

	// vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	// count saturated to the store depth
	assign cnt_ext = CMP_W'(vcount_q);
	assign n_eff   = (cnt_ext > MAX_EXT) ? MAX_EXT[CNT_W-1:0] : cnt_ext[CNT_W-1:0];

	// loads beyond the store are dropped
	assign slot_ext = SXW'(vertex_index);
	assign slot_ok  = slot_ext < MAX_SX;

	// read order: last vertex first, then 0 .. n-1
	assign addr_full = (rd_cnt_q == '0) ? (n_eff - 1'b1) : (rd_cnt_q - 1'b1);
	assign rd_addr   = addr_full[IDX_W-1:0];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pip_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		s_tready     = 1'b0;
		unique case (state_q)
			pip_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == pip_pkg::OP_TEST) begin
						cmd.start = 1'b1;
						state_d   = (n_eff == '0) ? pip_pkg::ST_DONE : pip_pkg::ST_RUN;
					end else begin
						cmd.wr_en = slot_ok;
					end
				end
			end
			pip_pkg::ST_RUN: begin
				cmd.rd_en = 1'b1;
				cmd.first = (rd_cnt_q == '0);
				if (rd_cnt_q == n_eff) begin
					state_d = pip_pkg::ST_DRAIN;
				end
			end
			pip_pkg::ST_DRAIN: begin
				if (!status.busy) begin
					state_d = pip_pkg::ST_DONE;
				end
			end
			pip_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = pip_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pip_pkg::ST_IDLE;
			end
		endcase
	end

	// read counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
		end else if (cmd.start) begin
			rd_cnt_q <= '0;
		end else if (cmd.rd_en) begin
			rd_cnt_q <= rd_cnt_q + 1'b1;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule
